@@ hdl/l2_vector_normalize_top_defines.svh @@
// Assertion macros for the L2 normalization block.
// They expect clk and rst_n in the scope where they are used.
`ifndef L2_VECTOR_NORMALIZE_TOP_DEFINES_SVH
`define L2_VECTOR_NORMALIZE_TOP_DEFINES_SVH

// Same-cycle implication.
`define L2VN_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("l2vn assertion failed");

// Next-cycle implication.
`define L2VN_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("l2vn assertion failed");

`endif

@@ hdl/l2vn_pkg.sv @@
package l2vn_pkg;

    localparam int SAMPLE_W = 16;
    localparam int EPS_W    = 36;
    localparam int SUM_W    = 37;
    localparam int SQ_W     = 31;

    // square root datapath
    localparam int ROOT_W     = 38;
    localparam int NORM_W     = 19;
    localparam int STEP_W     = 5;
    localparam int ROOT_STEPS = 19;
    localparam logic [ROOT_W-1:0] ROOT_BIT0 = ROOT_W'(1) << 36;

    // divider datapath
    localparam int REM_W     = 31;
    localparam int DIVR_W    = 34;
    localparam int LIMIT_W   = 35;
    localparam int QUO_STEPS = 16;

    localparam logic [SAMPLE_W-1:0] Q_POS_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] Q_NEG_MAX = 16'h8000;

    typedef enum logic [3:0] {
        S_LOAD,
        S_FLUSH,
        S_ROOT_START,
        S_ROOT,
        S_READ,
        S_DIV_START,
        S_DIV,
        S_EMIT
    } state_t;

endpackage

@@ hdl/l2vn_in_if.sv @@
interface l2vn_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [l2vn_pkg::SAMPLE_W-1:0]   sample;
    logic                                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

@@ hdl/l2vn_out_if.sv @@
interface l2vn_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [l2vn_pkg::SAMPLE_W-1:0]   normalized;
    logic                                   last_out;

    modport source (output valid, output normalized, output last_out, input ready);
    modport sink   (input valid, input normalized, input last_out, output ready);
endinterface

@@ hdl/l2_vector_normalize_top.sv @@
// Load: one element per cycle, ready held high until the closing element.
// After the closing element: flush, 19-step root, read, 16-step divide, emit.
// Each further result repeats read and radix-2 divide; emit waits out any output stall.
// Ready returns once the last result sits in the output register.
// Reset (async, active low) clears control, sum, count; epsilon resets to 1.
// Store contents are undefined after reset; only entries of the current vector are read.
`include "l2_vector_normalize_top_defines.svh"

module l2_vector_normalize_top
#(
    parameter int VEC_LEN = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [l2vn_pkg::EPS_W-1:0]      cfg_wdata,
    l2vn_in_if.sink                         samples,
    l2vn_out_if.source                      results
);

    localparam int AW = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
    localparam int CW = $clog2(VEC_LEN + 1);

    l2vn_pkg::state_t state_reg;
    l2vn_pkg::state_t state_next;

    logic [l2vn_pkg::EPS_W-1:0]            eps_reg;
    logic [l2vn_pkg::SUM_W-1:0]            sum_reg;
    logic [l2vn_pkg::SQ_W-1:0]             sq_reg;
    logic                                  pend_reg;
    logic [CW-1:0]                         count_reg;
    logic [AW-1:0]                         k_reg;
    logic [l2vn_pkg::NORM_W-1:0]           norm_reg;
    logic [l2vn_pkg::SAMPLE_W-1:0]         rdata_reg;
    logic                                  out_valid_reg;
    logic signed [l2vn_pkg::SAMPLE_W-1:0]  out_data_reg;
    logic                                  out_last_reg;

    logic [l2vn_pkg::SAMPLE_W-1:0]         store [VEC_LEN];

    logic                                  in_ready;
    logic                                  root_start;
    logic                                  rd_en;
    logic                                  div_start;
    logic                                  emit;
    logic                                  accept;
    logic                                  closing;
    logic                                  out_free;
    logic                                  final_k;
    logic [CW-1:0]                         count_inc;
    logic signed [2*l2vn_pkg::SAMPLE_W-1:0] prod;
    logic [l2vn_pkg::SUM_W-1:0]            eps_ext;
    logic [l2vn_pkg::SUM_W-1:0]            radicand;
    logic                                  root_done;
    logic [l2vn_pkg::NORM_W-1:0]           root;
    logic                                  div_done;
    logic signed [l2vn_pkg::SAMPLE_W-1:0]  quotient;

    assign accept    = samples.valid && in_ready;
    assign count_inc = count_reg + CW'(1);
    // a full vector closes even without the last flag
    assign closing   = samples.last || (count_inc == CW'(VEC_LEN));
    assign out_free  = !out_valid_reg || results.ready;
    assign final_k   = ((CW'(k_reg) + CW'(1)) == count_reg);
    assign prod      = samples.sample * samples.sample;
    assign eps_ext   = l2vn_pkg::SUM_W'(eps_reg);
    assign radicand  = (sum_reg > eps_ext) ? sum_reg : eps_ext;

    l2vn_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    l2vn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rdata_reg),
        .divisor  (norm_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            l2vn_pkg::S_LOAD:
            begin
                if (accept && closing)
                    state_next = l2vn_pkg::S_FLUSH;
            end
            l2vn_pkg::S_FLUSH:      state_next = l2vn_pkg::S_ROOT_START;
            l2vn_pkg::S_ROOT_START: state_next = l2vn_pkg::S_ROOT;
            l2vn_pkg::S_ROOT:
            begin
                if (root_done)
                    state_next = l2vn_pkg::S_READ;
            end
            l2vn_pkg::S_READ:       state_next = l2vn_pkg::S_DIV_START;
            l2vn_pkg::S_DIV_START:  state_next = l2vn_pkg::S_DIV;
            l2vn_pkg::S_DIV:
            begin
                if (div_done)
                    state_next = l2vn_pkg::S_EMIT;
            end
            l2vn_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = final_k ? l2vn_pkg::S_LOAD : l2vn_pkg::S_READ;
            end
            default:                state_next = l2vn_pkg::S_LOAD;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        root_start = 1'b0;
        rd_en      = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            l2vn_pkg::S_LOAD:       in_ready   = 1'b1;
            l2vn_pkg::S_ROOT_START: root_start = 1'b1;
            l2vn_pkg::S_READ:       rd_en      = 1'b1;
            l2vn_pkg::S_DIV_START:  div_start  = 1'b1;
            l2vn_pkg::S_EMIT:       emit       = out_free;
            default:                in_ready   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= l2vn_pkg::S_LOAD;
            eps_reg       <= l2vn_pkg::EPS_W'(1);
            sum_reg       <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
                eps_reg <= (cfg_wdata == '0) ? l2vn_pkg::EPS_W'(1) : cfg_wdata;

            // the square is registered on acceptance and added to the sum in the cycle after
            pend_reg <= accept;
            if (emit && final_k)
                sum_reg <= '0;
            else if (pend_reg)
                sum_reg <= sum_reg + l2vn_pkg::SUM_W'(sq_reg);

            if (accept)
                count_reg <= count_inc;
            else if (emit && final_k)
                count_reg <= '0;

            if (emit)
                k_reg <= final_k ? '0 : k_reg + AW'(1);

            if (emit)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store[count_reg[AW-1:0]] <= samples.sample;
            sq_reg                   <= prod[l2vn_pkg::SQ_W-1:0];
        end
        if (rd_en)
            rdata_reg <= store[k_reg];
        if (root_done)
            norm_reg <= root;
        if (emit)
        begin
            out_data_reg <= quotient;
            out_last_reg <= final_k;
        end
    end

    assign samples.ready      = in_ready;
    assign results.valid      = out_valid_reg;
    assign results.normalized = out_data_reg;
    assign results.last_out   = out_last_reg;

    `L2VN_ASSERT_IMP(a_ready_only_loading, samples.ready, (state_reg == l2vn_pkg::S_LOAD) && (count_reg < CW'(VEC_LEN)))
    `L2VN_ASSERT_IMP(a_root_done_in_root, root_done, state_reg == l2vn_pkg::S_ROOT)
    `L2VN_ASSERT_IMP(a_norm_nonzero, div_start, norm_reg != '0)
    `L2VN_ASSERT_NXT(a_emit_fills_output, emit, results.valid)

endmodule

@@ hdl/l2vn_isqrt.sv @@
module l2vn_isqrt
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [l2vn_pkg::SUM_W-1:0]      radicand,
    output logic                            done,
    output logic [l2vn_pkg::NORM_W-1:0]     root
);

    logic [l2vn_pkg::ROOT_W-1:0] x_reg;
    logic [l2vn_pkg::ROOT_W-1:0] res_reg;
    logic [l2vn_pkg::ROOT_W-1:0] bit_reg;
    logic [l2vn_pkg::STEP_W-1:0] step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [l2vn_pkg::ROOT_W-1:0] trial;
    logic                        take;

    assign trial = res_reg + bit_reg;
    assign take  = (x_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= l2vn_pkg::STEP_W'(l2vn_pkg::ROOT_STEPS);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - l2vn_pkg::STEP_W'(1);
            if (step_reg == l2vn_pkg::STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // one digit of the root per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= l2vn_pkg::ROOT_W'(radicand);
            res_reg <= '0;
            bit_reg <= l2vn_pkg::ROOT_BIT0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = (res_reg[l2vn_pkg::NORM_W-1:0] == '0) ? l2vn_pkg::NORM_W'(1)
                                                        : res_reg[l2vn_pkg::NORM_W-1:0];

endmodule

@@ hdl/l2vn_div.sv @@
module l2vn_div
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [l2vn_pkg::SAMPLE_W-1:0]    dividend,
    input  logic [l2vn_pkg::NORM_W-1:0]             divisor,
    output logic                                    done,
    output logic signed [l2vn_pkg::SAMPLE_W-1:0]    quotient
);

    logic [l2vn_pkg::REM_W-1:0]    r_reg;
    logic [l2vn_pkg::DIVR_W-1:0]   d_reg;
    logic [l2vn_pkg::SAMPLE_W-1:0] q_reg;
    logic                          sat_reg;
    logic                          neg_reg;
    logic [l2vn_pkg::STEP_W-1:0]   step_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [l2vn_pkg::SAMPLE_W-1:0] mag;
    logic [l2vn_pkg::REM_W-1:0]    mag_q15;
    logic [l2vn_pkg::LIMIT_W-1:0]  limit;
    logic                          take;

    assign mag     = dividend[l2vn_pkg::SAMPLE_W-1] ? l2vn_pkg::SAMPLE_W'(-dividend)
                                                    : l2vn_pkg::SAMPLE_W'(dividend);
    assign mag_q15 = {mag, 15'b0};
    // quotient of 2^16 or more saturates either way
    assign limit   = {divisor, 16'b0};
    assign take    = ({3'b0, r_reg} >= d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= l2vn_pkg::STEP_W'(l2vn_pkg::QUO_STEPS);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - l2vn_pkg::STEP_W'(1);
            if (step_reg == l2vn_pkg::STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= mag_q15;
            d_reg   <= {divisor, 15'b0};
            q_reg   <= '0;
            sat_reg <= ({4'b0, mag_q15} >= limit);
            neg_reg <= dividend[l2vn_pkg::SAMPLE_W-1];
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                r_reg <= r_reg - d_reg[l2vn_pkg::REM_W-1:0];
            end
            q_reg <= {q_reg[l2vn_pkg::SAMPLE_W-2:0], take};
            d_reg <= d_reg >> 1;
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (sat_reg || (q_reg > l2vn_pkg::Q_NEG_MAX))
                quotient = l2vn_pkg::Q_NEG_MAX;
            else
                quotient = l2vn_pkg::SAMPLE_W'(-q_reg);
        end
        else
        begin
            if (sat_reg || (q_reg > l2vn_pkg::Q_POS_MAX))
                quotient = l2vn_pkg::Q_POS_MAX;
            else
                quotient = q_reg;
        end
    end

    assign done = done_reg;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import l2vn_pkg::*;

    localparam int VEC_LEN       = 64;
    localparam int SETTLE_CYCLES = 60;    // root plus first divide, with margin
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 5000;
    localparam logic [EPS_W-1:0] EPS_MAX     = '1;
    localparam logic [EPS_W-1:0] EPS_ONE_Q30 = EPS_W'(1) << 30;

    typedef struct {
        logic signed [SAMPLE_W-1:0] normalized;
        logic                       last_out;
    } norm_result_t;

    typedef enum logic [1:0] { RX_FREE, RX_RANDOM, RX_PATTERN } rx_style_t;

    class norm_scoreboard;
        logic signed [SAMPLE_W-1:0] vec_elems[$];
        longint unsigned            sq_sum = 0;
        longint unsigned            eps = 1;
        norm_result_t               expected_q[$];
        int                         mismatches = 0;

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        function void set_epsilon(logic [EPS_W-1:0] v);
            eps = (v == 0) ? 1 : 64'(v);
        endfunction

        // digit-by-digit floor square root, fixed 19 steps
        function longint unsigned floor_root(longint unsigned x);
            longint unsigned rem;
            longint unsigned res;
            longint unsigned b;
            rem = x;
            res = 0;
            b = 64'd1 << 36;
            for (int i = 0; i < 19; i++)
            begin
                if (rem >= res + b)
                begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // truncating divide, saturated to Q1.15
        function logic signed [SAMPLE_W-1:0] scale_q15(logic signed [SAMPLE_W-1:0] e,
                                                      longint unsigned norm);
            longint          se;
            longint unsigned mag;
            longint unsigned q;
            se = e;
            mag = 64'(se < 0 ? -se : se) << 15;
            q = mag / norm;
            if (se < 0)
            begin
                if (q > 32768)
                    q = 32768;
                return SAMPLE_W'(-longint'(q));
            end
            if (q > 32767)
                q = 32767;
            return SAMPLE_W'(q);
        endfunction

        function void take_element(logic signed [SAMPLE_W-1:0] s, logic last);
            longint          sv;
            longint unsigned total;
            longint unsigned norm;
            norm_result_t    r;
            sv = s;
            vec_elems.push_back(s);
            sq_sum += 64'(sv * sv);
            // the element that fills the store closes the vector
            if (!last && vec_elems.size() < VEC_LEN)
                return;
            total = (sq_sum > eps) ? sq_sum : eps;
            norm = floor_root(total);
            if (norm == 0)
                norm = 1;
            foreach (vec_elems[k])
            begin
                r.normalized = scale_q15(vec_elems[k], norm);
                r.last_out = (k == vec_elems.size() - 1);
                expected_q.push_back(r);
            end
            vec_elems.delete();
            sq_sum = 0;
        endfunction

        task check_normalized(logic signed [SAMPLE_W-1:0] n, logic l);
            norm_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %0d last_out %0b", n, l));
                return;
            end
            want = expected_q.pop_front();
            if (n !== want.normalized)
                report_mismatch($sformatf("normalized %0d, want %0d", n, want.normalized));
            if (l !== want.last_out)
                report_mismatch($sformatf("last_out %0b, want %0b", l, want.last_out));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [EPS_W-1:0] cfg_wdata;
    bit               hold_req = 1'b0;
    int unsigned      burst_left = 0;
    int unsigned      items_sent = 0;
    int unsigned      quiet_cycles = 0;
    norm_scoreboard   sb;

    l2vn_in_if  samples_if ();
    l2vn_out_if results_if ();

    l2_vector_normalize_top #(.VEC_LEN(VEC_LEN)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (samples_if),
        .results   (results_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples_if.valid && samples_if.ready)
                sb.take_element(samples_if.sample, samples_if.last);
            if (results_if.valid && results_if.ready)
                sb.check_normalized(results_if.normalized, results_if.last_out);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (samples_if.valid && samples_if.ready) ||
            (results_if.valid && results_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("l2_vector_normalize_top verification failed");
            $finish;
        end
    end

    // result side: stall styles in segments, plus one long hold on request
    initial
    begin
        rx_style_t   style;
        int unsigned seg;
        int unsigned tick;
        results_if.ready = 1'b0;
        tick = 0;
        forever
        begin
            style = rx_style_t'($urandom_range(0, 2));
            seg = $urandom_range(20, 200);
            while (seg != 0 && !hold_req)
            begin
                @(negedge clk);
                case (style)
                    RX_FREE:   results_if.ready <= 1'b1;
                    RX_RANDOM: results_if.ready <= ($urandom_range(0, 99) < 55);
                    default:   results_if.ready <= ((tick % 7) < 4);
                endcase
                tick++;
                seg--;
            end
            if (hold_req)
            begin
                @(negedge clk);
                results_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
        end
    end

    // one request; bursts of random length with random gaps between them
    task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic l);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                @(negedge clk);
                samples_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        samples_if.valid <= 1'b1;
        samples_if.sample <= s;
        samples_if.last <= l;
        @(posedge clk);
        while (!samples_if.ready) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_all_normalized();
        @(negedge clk);
        samples_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_epsilon(v);
    endtask

    // per-vector shift sets the magnitude, with extremes mixed in
    task automatic send_vector(int unsigned len);
        int unsigned                shift;
        logic signed [SAMPLE_W-1:0] r;
        shift = $urandom_range(0, 15);
        for (int unsigned k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 11))
                0:       r = Q_POS_MAX;
                1:       r = Q_NEG_MAX;
                2:       r = '0;
                default: r = $signed(SAMPLE_W'($urandom)) >>> shift;
            endcase
            send_item(r, k == len - 1);
        end
    endtask

    task automatic random_phase(int unsigned n);
        int unsigned stop_at;
        int unsigned len;
        int unsigned pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 1)
                len = VEC_LEN + $urandom_range(1, 8);    // closes at the store limit
            else if (pick < 2)
                len = VEC_LEN;
            else if (pick < 18)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(1, 8);
            send_vector(len);
        end
        wait_all_normalized();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        samples_if.valid = 1'b0;
        samples_if.sample = '0;
        samples_if.last = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset epsilon: single-element vectors reach full scale both ways, then longer vectors follow
        send_item(Q_POS_MAX, 1'b1);
        send_item(Q_NEG_MAX, 1'b1);
        send_item(16'sd1, 1'b1);
        send_item(-16'sd1, 1'b1);
        send_item('0, 1'b1);
        send_item(Q_POS_MAX, 1'b0);
        send_item(Q_NEG_MAX, 1'b0);
        send_item('0, 1'b0);
        send_item(16'sd1, 1'b0);
        send_item(-16'sd1, 1'b0);
        send_item(16'sh3039, 1'b1);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b1);
        wait_all_normalized();

        // zero epsilon is held as one
        write_epsilon('0);
        send_item(16'sd1, 1'b1);
        send_item('0, 1'b1);
        wait_all_normalized();

        write_epsilon(EPS_MAX);
        send_item(16'sd100, 1'b1);
        send_item(Q_NEG_MAX, 1'b0);
        send_item(Q_POS_MAX, 1'b1);
        wait_all_normalized();

        write_epsilon(EPS_ONE_Q30);
        random_phase(75);

        // output held off while requests keep coming
        write_epsilon(EPS_W'(1));
        hold_req = 1'b1;
        random_phase(80);

        write_epsilon(EPS_W'($urandom_range(1, 1 << 20)));
        random_phase(70);
        write_epsilon(EPS_W'({$urandom, $urandom}));
        random_phase(65);
        write_epsilon(EPS_MAX);
        random_phase(60);

        if (sb.mismatches == 0)
            $display("l2_vector_normalize_top verification clean");
        else
            $display("l2_vector_normalize_top verification failed");
        $finish;
    end

endmodule

@@ l2_vector_normalize_top.f @@
+incdir+hdl
hdl/l2vn_pkg.sv
hdl/l2vn_in_if.sv
hdl/l2vn_out_if.sv
hdl/l2vn_isqrt.sv
hdl/l2vn_div.sv
hdl/l2_vector_normalize_top.sv
verif/tb.sv
